>>> hdl/cor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_pkg
// Shared constants, pipeline types, step functions and push saturation of the
// circle overlap resolver.
// ----------------------------------------------------------------------------
package cor_pkg;

    localparam int FRAC_BITS = 16;

    localparam int SQ_STEPS  = 2;
    localparam int SQ_STAGES = 32 / SQ_STEPS;
    localparam int DV_STEPS  = 2;
    localparam int DV_STAGES = 32 / DV_STEPS;

    typedef struct packed {
        logic [63:0] v;
        logic [32:0] rem;
        logic [31:0] root;
    } t_sq_st;

    typedef struct packed {
        logic        over;
        logic        degen;
        logic        neg_x;
        logic        neg_y;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] rsum;
        logic [30:0] rmax;
    } t_sq_side;

    typedef struct packed {
        logic [31:0] lo;
        logic [32:0] rem;
        logic [31:0] q;
    } t_dv_st;

    typedef struct packed {
        logic over;
        logic degen;
        logic push_en;
        logic neg_x;
        logic neg_y;
    } t_dv_side;

    function automatic t_sq_st sqrt_step(input t_sq_st s);
        logic [34:0] rem_n;
        logic [34:0] trial;
        t_sq_st      r;
        rem_n = {s.rem, s.v[63:62]};
        trial = {1'b0, s.root, 2'b01};
        r.v   = {s.v[61:0], 2'b00};
        if (rem_n >= trial) begin
            r.rem  = 33'(rem_n - trial);
            r.root = {s.root[30:0], 1'b1};
        end else begin
            r.rem  = rem_n[32:0];
            r.root = {s.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic t_dv_st div_step(input t_dv_st s, input logic [32:0] den);
        logic [33:0] rem_n;
        t_dv_st      r;
        rem_n = {s.rem, s.lo[31]};
        r.lo  = {s.lo[30:0], 1'b0};
        if (rem_n >= {1'b0, den}) begin
            r.rem = 33'(rem_n - {1'b0, den});
            r.q   = {s.q[30:0], 1'b1};
        end else begin
            r.rem = rem_n[32:0];
            r.q   = {s.q[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_push(input logic [31:0] q, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (q > 32'h8000_0000) ? 32'h8000_0000 : 32'(~q + 32'd1);
        end else begin
            r = (q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
        return r;
    endfunction

endpackage

>>> hdl/circle_overlap_resolver_top.sv
`timescale 1ns / 1ps
// The pipeline has 40 register stages.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// The square root (16 stages) and the push divider (16 stages) set the depth.
// Reset clears all stage valid bits and the wiggle margin; payload is not reset.
// ----------------------------------------------------------------------------
// circle_overlap_resolver_top
// Overlap test and separation push for a pair of circles in signed Q16.16.
// ----------------------------------------------------------------------------
module circle_overlap_resolver_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [30:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_radius, second_x, second_y, second_radius, pad
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // overlapping, degenerate, push_x, push_y, pad
    output logic [71:0]  m_axis_tdata
);

    logic        w_en;
    logic [30:0] r_margin;

    logic               r_s1_vld;
    logic signed [32:0] r_s1_dx;
    logic signed [32:0] r_s1_dy;
    logic [30:0]        r_s1_ra;
    logic [30:0]        r_s1_rb;

    logic        r_s2_vld;
    logic [31:0] r_s2_ax;
    logic [31:0] r_s2_ay;
    logic        r_s2_nx;
    logic        r_s2_ny;
    logic [31:0] r_s2_rsum;
    logic [30:0] r_s2_rmax;

    logic        r_s3_vld;
    logic [63:0] r_s3_sx;
    logic [63:0] r_s3_sy;
    logic [63:0] r_s3_rsq;
    logic [31:0] r_s3_ax;
    logic [31:0] r_s3_ay;
    logic        r_s3_nx;
    logic        r_s3_ny;
    logic [31:0] r_s3_rsum;
    logic [30:0] r_s3_rmax;

    logic        r_s4_vld;
    logic [64:0] r_s4_d2;
    logic [63:0] r_s4_rsqm;
    logic        r_s4_rsq_ge;
    logic [31:0] r_s4_ax;
    logic [31:0] r_s4_ay;
    logic        r_s4_nx;
    logic        r_s4_ny;
    logic [31:0] r_s4_rsum;
    logic [30:0] r_s4_rmax;

    logic              r_s5_vld;
    logic [63:0]       r_s5_d2;
    cor_pkg::t_sq_side r_s5_side;

    logic [63:0]       w_msq;
    logic              w_over;
    logic              w_degen;

    logic              w_sq_vld;
    logic [31:0]       w_root;
    cor_pkg::t_sq_side w_sq_side;

    logic              r_s6_vld;
    logic [32:0]       r_s6_h2;
    logic [32:0]       r_s6_den;
    logic [31:0]       r_s6_ax;
    logic [31:0]       r_s6_ay;
    cor_pkg::t_dv_side r_s6_side;

    logic              r_s7_vld;
    logic [64:0]       r_s7_nx;
    logic [64:0]       r_s7_ny;
    logic [32:0]       r_s7_den;
    cor_pkg::t_dv_side r_s7_side;

    logic              w_dv_vld;
    logic [31:0]       w_qx;
    logic [31:0]       w_qy;
    cor_pkg::t_dv_side w_dv_side;

    logic        r_out_vld;
    logic        r_out_over;
    logic        r_out_degen;
    logic [31:0] r_out_px;
    logic [31:0] r_out_py;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= '0;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    // valid chain of the top-level stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld  <= s_axis_tvalid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= r_s4_vld;
            r_s6_vld  <= w_sq_vld;
            r_s7_vld  <= r_s6_vld;
            r_out_vld <= w_dv_vld;
        end
    end

    assign w_msq   = 64'(r_margin) << cor_pkg::FRAC_BITS;
    assign w_over  = !r_s4_d2[64] && r_s4_rsq_ge && (r_s4_d2[63:0] < r_s4_rsqm);
    assign w_degen = !r_s4_d2[64] && (r_s4_d2[63:0] < w_msq);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // centre differences
            r_s1_dx <= 33'($signed(s_axis_tdata[31:0])) - 33'($signed(s_axis_tdata[126:95]));
            r_s1_dy <= 33'($signed(s_axis_tdata[63:32])) - 33'($signed(s_axis_tdata[158:127]));
            r_s1_ra <= s_axis_tdata[94:64];
            r_s1_rb <= s_axis_tdata[189:159];

            // magnitudes, radius sum and larger radius
            r_s2_ax   <= r_s1_dx[32] ? 32'(-r_s1_dx) : r_s1_dx[31:0];
            r_s2_ay   <= r_s1_dy[32] ? 32'(-r_s1_dy) : r_s1_dy[31:0];
            r_s2_nx   <= r_s1_dx[32];
            r_s2_ny   <= r_s1_dy[32];
            r_s2_rsum <= 32'(r_s1_ra) + 32'(r_s1_rb);
            r_s2_rmax <= (r_s1_ra > r_s1_rb) ? r_s1_ra : r_s1_rb;

            // squares
            r_s3_sx   <= 64'(r_s2_ax) * 64'(r_s2_ax);
            r_s3_sy   <= 64'(r_s2_ay) * 64'(r_s2_ay);
            r_s3_rsq  <= 64'(r_s2_rsum) * 64'(r_s2_rsum);
            r_s3_ax   <= r_s2_ax;
            r_s3_ay   <= r_s2_ay;
            r_s3_nx   <= r_s2_nx;
            r_s3_ny   <= r_s2_ny;
            r_s3_rsum <= r_s2_rsum;
            r_s3_rmax <= r_s2_rmax;

            // squared distance and threshold
            r_s4_d2     <= 65'(r_s3_sx) + 65'(r_s3_sy);
            r_s4_rsqm   <= r_s3_rsq - w_msq;
            r_s4_rsq_ge <= r_s3_rsq >= w_msq;
            r_s4_ax     <= r_s3_ax;
            r_s4_ay     <= r_s3_ay;
            r_s4_nx     <= r_s3_nx;
            r_s4_ny     <= r_s3_ny;
            r_s4_rsum   <= r_s3_rsum;
            r_s4_rmax   <= r_s3_rmax;

            // overlap and degenerate flags
            r_s5_d2         <= r_s4_d2[63:0];
            r_s5_side.over  <= w_over;
            r_s5_side.degen <= w_degen;
            r_s5_side.neg_x <= r_s4_nx;
            r_s5_side.neg_y <= r_s4_ny;
            r_s5_side.ax    <= r_s4_ax;
            r_s5_side.ay    <= r_s4_ay;
            r_s5_side.rsum  <= r_s4_rsum;
            r_s5_side.rmax  <= r_s4_rmax;
        end
    end

    cor_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s5_vld),
        .i_d2    (r_s5_d2),
        .i_side  (r_s5_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // twice the half overlap
            r_s6_h2 <= 33'(w_sq_side.rsum) - 33'(w_root)
                     + ((w_root < 32'(w_sq_side.rmax)) ? 33'd0 : {1'b0, r_margin, 1'b0});
            r_s6_den          <= {w_root, 1'b0};
            r_s6_ax           <= w_sq_side.ax;
            r_s6_ay           <= w_sq_side.ay;
            r_s6_side.over    <= w_sq_side.over;
            r_s6_side.degen   <= w_sq_side.degen;
            r_s6_side.push_en <= w_sq_side.over && !w_sq_side.degen && (w_root != 32'd0);
            r_s6_side.neg_x   <= w_sq_side.neg_x;
            r_s6_side.neg_y   <= w_sq_side.neg_y;

            r_s7_nx   <= 65'(r_s6_h2) * 65'(r_s6_ax);
            r_s7_ny   <= 65'(r_s6_h2) * 65'(r_s6_ay);
            r_s7_den  <= r_s6_den;
            r_s7_side <= r_s6_side;
        end
    end

    cor_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s7_vld),
        .i_num_x (r_s7_nx),
        .i_num_y (r_s7_ny),
        .i_den   (r_s7_den),
        .i_side  (r_s7_side),
        .o_vld   (w_dv_vld),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_side  (w_dv_side)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_over  <= w_dv_side.over;
            r_out_degen <= w_dv_side.degen;
            r_out_px    <= w_dv_side.push_en ? cor_pkg::sat_push(w_qx, w_dv_side.neg_x) : '0;
            r_out_py    <= w_dv_side.push_en ? cor_pkg::sat_push(w_qy, w_dv_side.neg_y) : '0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_out_py, r_out_px, r_out_degen, r_out_over};

endmodule

>>> hdl/cor_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_sqrt
// Pipelined integer square root of a 64-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module cor_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [63:0]         i_d2,
    input  cor_pkg::t_sq_side   i_side,
    output logic                o_vld,
    output logic [31:0]         o_root,
    output cor_pkg::t_sq_side   o_side
);

    cor_pkg::t_sq_st   r_st   [cor_pkg::SQ_STAGES];
    cor_pkg::t_sq_side r_side [cor_pkg::SQ_STAGES];
    logic [cor_pkg::SQ_STAGES-1:0] r_vld;

    cor_pkg::t_sq_st   w_prev      [cor_pkg::SQ_STAGES];
    cor_pkg::t_sq_side w_side_prev [cor_pkg::SQ_STAGES];
    logic [cor_pkg::SQ_STAGES-1:0] w_vld_prev;
    cor_pkg::t_sq_st   n_st        [cor_pkg::SQ_STAGES];

    always_comb begin
        w_prev[0]      = '{v: i_d2, rem: '0, root: '0};
        w_side_prev[0] = i_side;
        w_vld_prev[0]  = i_vld;
        for (int k = 1; k < cor_pkg::SQ_STAGES; k++) begin
            w_prev[k]      = r_st[k-1];
            w_side_prev[k] = r_side[k-1];
            w_vld_prev[k]  = r_vld[k-1];
        end
    end

    always_comb begin
        cor_pkg::t_sq_st t;
        for (int k = 0; k < cor_pkg::SQ_STAGES; k++) begin
            t = w_prev[k];
            for (int j = 0; j < cor_pkg::SQ_STEPS; j++) begin
                t = cor_pkg::sqrt_step(t);
            end
            n_st[k] = t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= w_vld_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < cor_pkg::SQ_STAGES; k++) begin
                r_st[k]   <= n_st[k];
                r_side[k] <= w_side_prev[k];
            end
        end
    end

    assign o_vld  = r_vld[cor_pkg::SQ_STAGES-1];
    assign o_root = r_st[cor_pkg::SQ_STAGES-1].root;
    assign o_side = r_side[cor_pkg::SQ_STAGES-1];

endmodule

>>> hdl/cor_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cor_div
// Pipelined restoring divider for both push components, two quotient bits
// per stage; the quotient is known to fit in 32 bits.
// ----------------------------------------------------------------------------
module cor_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [64:0]         i_num_x,
    input  logic [64:0]         i_num_y,
    input  logic [32:0]         i_den,
    input  cor_pkg::t_dv_side   i_side,
    output logic                o_vld,
    output logic [31:0]         o_q_x,
    output logic [31:0]         o_q_y,
    output cor_pkg::t_dv_side   o_side
);

    cor_pkg::t_dv_st   r_sx   [cor_pkg::DV_STAGES];
    cor_pkg::t_dv_st   r_sy   [cor_pkg::DV_STAGES];
    logic [32:0]       r_den  [cor_pkg::DV_STAGES];
    cor_pkg::t_dv_side r_side [cor_pkg::DV_STAGES];
    logic [cor_pkg::DV_STAGES-1:0] r_vld;

    cor_pkg::t_dv_st   w_px   [cor_pkg::DV_STAGES];
    cor_pkg::t_dv_st   w_py   [cor_pkg::DV_STAGES];
    logic [32:0]       w_den  [cor_pkg::DV_STAGES];
    cor_pkg::t_dv_side w_side [cor_pkg::DV_STAGES];
    logic [cor_pkg::DV_STAGES-1:0] w_vld;
    cor_pkg::t_dv_st   n_sx   [cor_pkg::DV_STAGES];
    cor_pkg::t_dv_st   n_sy   [cor_pkg::DV_STAGES];

    always_comb begin
        w_px[0]   = '{lo: i_num_x[31:0], rem: i_num_x[64:32], q: '0};
        w_py[0]   = '{lo: i_num_y[31:0], rem: i_num_y[64:32], q: '0};
        w_den[0]  = i_den;
        w_side[0] = i_side;
        w_vld[0]  = i_vld;
        for (int k = 1; k < cor_pkg::DV_STAGES; k++) begin
            w_px[k]   = r_sx[k-1];
            w_py[k]   = r_sy[k-1];
            w_den[k]  = r_den[k-1];
            w_side[k] = r_side[k-1];
            w_vld[k]  = r_vld[k-1];
        end
    end

    always_comb begin
        cor_pkg::t_dv_st tx;
        cor_pkg::t_dv_st ty;
        for (int k = 0; k < cor_pkg::DV_STAGES; k++) begin
            tx = w_px[k];
            ty = w_py[k];
            for (int j = 0; j < cor_pkg::DV_STEPS; j++) begin
                tx = cor_pkg::div_step(tx, w_den[k]);
                ty = cor_pkg::div_step(ty, w_den[k]);
            end
            n_sx[k] = tx;
            n_sy[k] = ty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < cor_pkg::DV_STAGES; k++) begin
                r_sx[k]   <= n_sx[k];
                r_sy[k]   <= n_sy[k];
                r_den[k]  <= w_den[k];
                r_side[k] <= w_side[k];
            end
        end
    end

    assign o_vld  = r_vld[cor_pkg::DV_STAGES-1];
    assign o_q_x  = r_sx[cor_pkg::DV_STAGES-1].q;
    assign o_q_y  = r_sy[cor_pkg::DV_STAGES-1].q;
    assign o_side = r_side[cor_pkg::DV_STAGES-1];

endmodule
